// File: sv/rnd_pkg.sv
package rnd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned COUNT_W  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [1:0] OP_DELTA   = 2'b00;
  localparam logic [1:0] OP_REPEAT  = 2'b01;
  localparam logic [1:0] OP_SKIP    = 2'b10;
  localparam logic [1:0] OP_LITERAL = 2'b11;

  typedef enum logic [2:0] {
    MODE_CMD,
    MODE_LIT,
    MODE_REP,
    MODE_SKIPCNT,
    MODE_DFIRST,
    MODE_DNIB
  } mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] len;
  } run_t;

  typedef struct packed {
    run_t run0;
    logic has1;
    run_t run1;
  } entry_t;

  function automatic logic [BYTE_W-1:0] delta_add(input logic [3:0] nib);
    delta_add = {{(BYTE_W-4){nib[3]}}, nib};
  endfunction

  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [BYTE_W:0] b);
    logic [POS_W:0] sum;
    sum = {1'b0, a} + (POS_W+1)'(b);
    sat_add = sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];
  endfunction

endpackage

// File: sv/rnd_front.sv
module rnd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rnd_pkg::BYTE_W-1:0]    in_stream_byte,
  input  logic                          in_frame_start,
  input  logic                          q_full,
  output logic                          q_push,
  output rnd_pkg::entry_t               q_entry
);
  import rnd_pkg::*;

  mode_t               mode_r, mode_nxt, mode_eff;
  logic [COUNT_W-1:0]  pend_r, pend_nxt, pend_eff, pend_m1, pend_m2;
  logic [BYTE_W-1:0]   rv_r, rv_nxt, rv_eff;
  logic [POS_W-1:0]    pos_r, pos_nxt, pos_eff;

  logic                accept;
  logic [BYTE_W-1:0]   b;
  logic [5:0]          cnt;
  logic [1:0]          op;
  logic [BYTE_W-1:0]   v1, v2;
  logic [BYTE_W-1:0]   run0_value, run0_len, run1_value;
  logic                has1;
  logic [BYTE_W:0]     pos_adv;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_stream_byte;
  assign cnt      = b[7:2];
  assign op       = b[1:0];

  assign mode_eff = in_frame_start ? MODE_CMD : mode_r;
  assign pend_eff = in_frame_start ? '0 : pend_r;
  assign rv_eff   = in_frame_start ? '0 : rv_r;
  assign pos_eff  = in_frame_start ? '0 : pos_r;

  assign pend_m1  = pend_eff - COUNT_W'(1);
  assign pend_m2  = pend_eff - COUNT_W'(2);
  assign v1       = rv_eff + delta_add(b[7:4]);
  assign v2       = v1 + delta_add(b[3:0]);

  // next parse mode
  always_comb begin
    mode_nxt = MODE_CMD;
    case (mode_eff)
      MODE_LIT:     mode_nxt = MODE_CMD;
      MODE_REP:     mode_nxt = MODE_CMD;
      MODE_SKIPCNT: mode_nxt = MODE_CMD;
      MODE_DFIRST:  mode_nxt = (pend_m1 == '0) ? MODE_CMD : MODE_DNIB;
      MODE_DNIB: begin
        if (pend_m1 == '0 || pend_m2 == '0) mode_nxt = MODE_CMD;
        else mode_nxt = MODE_DNIB;
      end
      MODE_CMD: begin
        case (op)
          OP_LITERAL: mode_nxt = MODE_LIT;
          OP_REPEAT:  mode_nxt = MODE_REP;
          OP_SKIP:    mode_nxt = (cnt == '0) ? MODE_SKIPCNT : MODE_CMD;
          OP_DELTA:   mode_nxt = (cnt == '0) ? MODE_CMD : MODE_DFIRST;
          default:    mode_nxt = MODE_CMD;
        endcase
      end
      default: mode_nxt = MODE_CMD;
    endcase
  end

  // runs and datapath state
  always_comb begin
    pend_nxt   = pend_eff;
    rv_nxt     = rv_eff;
    run0_value = '0;
    run0_len   = '0;
    run1_value = '0;
    has1       = 1'b0;
    case (mode_eff)
      MODE_LIT: begin
        run0_value = b;
        run0_len   = BYTE_W'(1);
      end
      MODE_REP: begin
        run0_value = b;
        run0_len   = BYTE_W'(pend_eff);
        pend_nxt   = '0;
      end
      MODE_SKIPCNT: begin
        run0_len = b;
      end
      MODE_DFIRST: begin
        rv_nxt     = b;
        run0_value = b;
        run0_len   = BYTE_W'(1);
        pend_nxt   = pend_m1;
      end
      MODE_DNIB: begin
        run0_value = v1;
        run0_len   = BYTE_W'(1);
        if (pend_m1 != '0) begin
          has1       = 1'b1;
          run1_value = v2;
          rv_nxt     = v2;
          pend_nxt   = pend_m2;
        end else begin
          rv_nxt   = v1;
          pend_nxt = pend_m1;
        end
      end
      MODE_CMD: begin
        case (op)
          OP_REPEAT: pend_nxt = cnt;
          OP_SKIP:   run0_len = BYTE_W'(cnt);
          OP_DELTA: begin
            if (cnt != '0) pend_nxt = cnt;
          end
          default: pend_nxt = pend_eff;
        endcase
      end
      default: pend_nxt = pend_eff;
    endcase
  end

  assign pos_adv = {1'b0, run0_len} + (BYTE_W+1)'(has1);
  assign pos_nxt = sat_add(pos_eff, pos_adv);

  assign q_entry.run0.value = run0_value;
  assign q_entry.run0.pos   = pos_eff;
  assign q_entry.run0.len   = run0_len;
  assign q_entry.has1       = has1;
  assign q_entry.run1.value = run1_value;
  assign q_entry.run1.pos   = sat_add(pos_eff, (BYTE_W+1)'(1));
  assign q_entry.run1.len   = BYTE_W'(1);
  assign q_push             = accept && (run0_len != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CMD;
      pend_r <= '0;
      rv_r   <= '0;
      pos_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      rv_r   <= rv_nxt;
      pos_r  <= pos_nxt;
    end
  end

  a_delta_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DNIB || mode_r == MODE_DFIRST) |-> pend_r != '0)
    else $error("delta mode with no pixels left");

endmodule

// File: sv/rnd_queue.sv
module rnd_queue #(
  parameter int unsigned DEPTH = rnd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rnd_pkg::entry_t push_entry,
  output logic            full,
  output logic            empty,
  output rnd_pkg::entry_t head,
  input  logic            pop
);
  import rnd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop) rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// File: sv/rnd_back.sv
module rnd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rnd_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          q_empty,
  input  rnd_pkg::entry_t               q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rnd_pkg::BYTE_W-1:0]    out_pixel_value,
  output logic [rnd_pkg::POS_W-1:0]     out_start_position,
  output logic [rnd_pkg::BYTE_W-1:0]    out_run_length,
  output logic                          out_last_of_item
);
  import rnd_pkg::*;

  logic [CFG_W-1:0]   width_r, height_r;
  logic [POS_W-1:0]   total_r;

  logic               sub_r, sub_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  value_r, value_nxt, len_r, len_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               last_r, last_nxt;

  logic               load_ok, k0, k1, emit;
  logic [POS_W-1:0]   remain0;
  logic [BYTE_W-1:0]  len0_clip;

  assign load_ok   = !out_valid_r || !out_stall;
  assign k0        = q_head.run0.pos < total_r;
  assign k1        = q_head.has1 && (q_head.run1.pos < total_r);
  assign remain0   = total_r - q_head.run0.pos;
  assign len0_clip = (remain0 < POS_W'(q_head.run0.len)) ? remain0[BYTE_W-1:0]
                                                        : q_head.run0.len;

  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    sub_nxt   = sub_r;
    value_nxt = value_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    last_nxt  = last_r;
    if (!q_empty && load_ok) begin
      if (!sub_r && k0) begin
        emit      = 1'b1;
        value_nxt = q_head.run0.value;
        pos_nxt   = q_head.run0.pos;
        len_nxt   = len0_clip;
        last_nxt  = !k1;
        if (k1) sub_nxt = 1'b1;
        else q_pop = 1'b1;
      end else begin
        emit      = k1;
        value_nxt = q_head.run1.value;
        pos_nxt   = q_head.run1.pos;
        len_nxt   = q_head.run1.len;
        last_nxt  = 1'b1;
        q_pop     = 1'b1;
        sub_nxt   = 1'b0;
      end
    end
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      total_r  <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_WIDTH) width_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_HEIGHT) height_r <= cfg_wdata;
      total_r <= width_r * height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value_r <= value_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_value    = value_r;
  assign out_start_position = pos_r;
  assign out_run_length     = len_r;
  assign out_last_of_item   = last_r;

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> len_r != '0)
    else $error("empty run on output");

  a_second_run_held: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (!q_empty && q_head.has1))
    else $error("second run pending without queue entry");

endmodule

// File: sv/rle_nibble_delta_image_decoder.sv
// the first run of a byte passes through the queue memory and then the output registers
// throughput: one byte per cycle while in_stall is low; a delta byte carrying two pixels gives two output runs
// a queue of QUEUE_DEPTH entries between parser and run emitter absorbs those bursts
// config writes reach the clip limit through the width/height registers and then the registered w*h product
// rst_n is synchronous, active low: parser idle, position zero, queue and output empty
module rle_nibble_delta_image_decoder #(
  parameter int unsigned QUEUE_DEPTH = rnd_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rnd_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rnd_pkg::BYTE_W-1:0]    in_stream_byte,
  input  logic                          in_frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rnd_pkg::BYTE_W-1:0]    out_pixel_value,
  output logic [rnd_pkg::POS_W-1:0]     out_start_position,
  output logic [rnd_pkg::BYTE_W-1:0]    out_run_length,
  output logic                          out_last_of_item
);
  import rnd_pkg::*;

  logic   q_push, q_full, q_empty, q_pop;
  entry_t q_entry, q_head;

  rnd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .in_frame_start (in_frame_start),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  rnd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head),
    .pop        (q_pop)
  );

  rnd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_value    (out_pixel_value),
    .out_start_position (out_start_position),
    .out_run_length     (out_run_length),
    .out_last_of_item   (out_last_of_item)
  );

endmodule

// File: sim/rle_nibble_delta_image_decoder_test.sv
`timescale 1ns / 100ps

module rle_nibble_delta_image_decoder_test;
  import rnd_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] len;
    logic              last;
  } run_exp_t;

  class run_scoreboard;
    run_exp_t runs_due[$];
    run_exp_t fresh[$];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    mode_t mode;
    logic [COUNT_W-1:0] count_left;
    logic [BYTE_W-1:0] delta_sum;
    logic [POS_W-1:0] next_pos;
    int errors;

    function new();
      width_reg = '0;
      height_reg = '0;
      clear_parser();
      errors = 0;
    endfunction

    function void clear_parser();
      mode = MODE_CMD;
      count_left = '0;
      delta_sum = '0;
      next_pos = '0;
    endfunction

    function void set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
      width_reg = w;
      height_reg = h;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    // position always advances by the full length, saturating; runs clip to w*h
    function void place_run(logic [BYTE_W-1:0] value, int unsigned len);
      logic [POS_W-1:0] total;
      logic [POS_W-1:0] at;
      run_exp_t r;
      total = width_reg * height_reg;
      at = next_pos;
      if (next_pos > 32'hFFFF_FFFF - len) next_pos = '1;
      else next_pos = next_pos + len;
      if (len == 0 || at >= total) return;
      if (len > total - at) len = total - at;
      r.value = value;
      r.pos = at;
      r.len = len[BYTE_W-1:0];
      r.last = 1'b0;
      fresh.push_back(r);
    endfunction

    function void step_delta(logic [3:0] nib);
      delta_sum = delta_sum + {{4{nib[3]}}, nib};
      place_run(delta_sum, 1);
      count_left = count_left - COUNT_W'(1);
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic fs);
      fresh.delete();
      if (fs) clear_parser();
      case (mode)
        MODE_LIT: begin
          place_run(b, 1);
          mode = MODE_CMD;
        end
        MODE_REP: begin
          place_run(b, count_left);
          count_left = '0;
          mode = MODE_CMD;
        end
        MODE_SKIPCNT: begin
          place_run('0, b);
          mode = MODE_CMD;
        end
        MODE_DFIRST: begin
          delta_sum = b;
          place_run(b, 1);
          count_left = count_left - COUNT_W'(1);
          mode = (count_left == 0) ? MODE_CMD : MODE_DNIB;
        end
        MODE_DNIB: begin
          step_delta(b[7:4]);
          if (count_left != 0) step_delta(b[3:0]);
          if (count_left == 0) mode = MODE_CMD;
        end
        default: begin
          case (b[1:0])
            OP_LITERAL: mode = MODE_LIT;
            OP_REPEAT: begin
              count_left = b[7:2];
              mode = MODE_REP;
            end
            OP_SKIP: begin
              if (b[7:2] == 0) mode = MODE_SKIPCNT;
              else begin
                place_run('0, b[7:2]);
                mode = MODE_CMD;
              end
            end
            default: begin
              if (b[7:2] != 0) begin
                count_left = b[7:2];
                mode = MODE_DFIRST;
              end else mode = MODE_CMD;
            end
          endcase
        end
      endcase
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) runs_due.push_back(fresh[i]);
    endfunction

    task check_run(logic [BYTE_W-1:0] v, logic [POS_W-1:0] p, logic [BYTE_W-1:0] l,
                   logic last);
      run_exp_t e;
      if (runs_due.size() == 0) begin
        report_mismatch($sformatf("unexpected run value %0h pos %0d len %0d", v, p, l));
        return;
      end
      e = runs_due.pop_front();
      if (v !== e.value)
        report_mismatch($sformatf("pixel_value %0h, want %0h", v, e.value));
      if (p !== e.pos)
        report_mismatch($sformatf("start_position %0d, want %0d", p, e.pos));
      if (l !== e.len)
        report_mismatch($sformatf("run_length %0d, want %0d", l, e.len));
      if (last !== e.last)
        report_mismatch($sformatf("last_of_item %0b, want %0b", last, e.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_stream_byte = '0;
  logic                 in_frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_pixel_value;
  logic [POS_W-1:0]     out_start_position;
  logic [BYTE_W-1:0]    out_run_length;
  logic                 out_last_of_item;

  run_scoreboard board;
  bit steady = 1'b0;
  int beats_sent = 0;
  int quiet = 0;

  rle_nibble_delta_image_decoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_stream_byte     (in_stream_byte),
    .in_frame_start     (in_frame_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_value    (out_pixel_value),
    .out_start_position (out_start_position),
    .out_run_length     (out_run_length),
    .out_last_of_item   (out_last_of_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0)
      board.check_run(out_pixel_value, out_start_position, out_run_length, out_last_of_item);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fs);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_byte <= b;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_byte(b, fs);
    beats_sent++;
  endtask

  task automatic write_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_size(w, h);
    repeat (4) @(posedge clk);
  endtask

  // extremes, zero counts, clipping, wrapping deltas and an unused low nibble
  task automatic send_opening();
    send_byte(8'h03, 1'b1); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'hAA, 1'b0);
    send_byte(8'hFD, 1'b0); send_byte(8'h55, 1'b0);
    send_byte(8'h02, 1'b1); send_byte(8'hFF, 1'b0);
    send_byte(8'h0A, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h14, 1'b0); send_byte(8'hFC, 1'b0);
    send_byte(8'h7F, 1'b0); send_byte(8'h8F, 1'b0);
    send_byte(8'h08, 1'b0); send_byte(8'h10, 1'b0); send_byte(8'h3A, 1'b0);
    send_byte(8'h04, 1'b0); send_byte(8'h42, 1'b0);
    send_byte(8'h09, 1'b0); send_byte(8'h77, 1'b0);
    send_byte(8'h07, 1'b0); send_byte(8'h33, 1'b0);
  endtask

  task automatic send_sequence();
    logic [BYTE_W-1:0] cmd;
    logic fs;
    int unsigned n;
    fs = ($urandom_range(11) == 0);
    if ($urandom_range(99) < 12) begin
      send_byte(BYTE_W'($urandom), $urandom_range(15) == 0);
      return;
    end
    cmd[1:0] = 2'($urandom_range(3));
    cmd[7:2] = ($urandom_range(4) == 0) ? 6'($urandom_range(3)) : 6'($urandom);
    send_byte(cmd, fs);
    case (cmd[1:0])
      OP_LITERAL, OP_REPEAT: send_byte(BYTE_W'($urandom), 1'b0);
      OP_SKIP: if (cmd[7:2] == 0) send_byte(BYTE_W'($urandom), 1'b0);
      default: begin
        if (cmd[7:2] != 0) begin
          n = cmd[7:2] / 2;
          // occasionally cut the sequence short
          if ($urandom_range(14) == 0) n = $urandom_range(n);
          send_byte(BYTE_W'($urandom), 1'b0);
          repeat (n) send_byte(BYTE_W'($urandom), 1'b0);
        end
      end
    endcase
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int count, input bit opening);
    int first;
    write_size(w, h);
    first = beats_sent;
    if (opening) send_opening();
    while (beats_sent - first < count) send_sequence();
    in_valid <= 1'b0;
    while (board.runs_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    run_phase(16'd4, 16'd3, 125, 1'b1);
    run_phase(16'd0, 16'd0, 80, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 150, 1'b0);
    steady = 1'b1;
    run_phase(16'd16, 16'd8, 200, 1'b0);
    steady = 1'b0;
    run_phase(16'd1, 16'd1, 80, 1'b0);
    run_phase(16'd0, 16'hFFFF, 60, 1'b0);
    run_phase(16'hFFFF, 16'd0, 60, 1'b0);
    run_phase(16'd300, 16'd3, 105, 1'b0);
    run_phase(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 16)), 130, 1'b0);
    run_phase(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 16)), 130, 1'b0);
    run_phase(CFG_W'($urandom), CFG_W'($urandom_range(0, 3)), 130, 1'b0);
    repeat (10) @(posedge clk);
    if (board.runs_due.size() != 0)
      board.report_mismatch($sformatf("%0d runs never arrived", board.runs_due.size()));
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
